FILE: src/gss_pkg.sv
`timescale 1ns / 1ps
// Package for the generational sparse-set store.
// Sizes, mode and status codes, memory word layouts. No dependencies.
package gss_pkg;

  localparam int MAX_ITEMS  = 1024;
  localparam int SLOT_W     = 10;
  localparam int CNT_W      = 11;
  localparam int ENT_W      = 10;
  localparam int ENT_COUNT  = 1024;
  localparam int GEN_W      = 16;
  localparam int VAL_W      = 32;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_LOOKUP = 2'd2;
  localparam logic [1:0] MODE_SLOT   = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_MISS    = 2'd1;
  localparam logic [1:0] ST_PRESENT = 2'd2;
  localparam logic [1:0] ST_FULL    = 2'd3;

  // word of the entity-indexed memory
  typedef struct packed {
    logic              valid;
    logic [GEN_W-1:0]  gen;
    logic [SLOT_W-1:0] slot;
  } ent_word_t;

  // word of the slot-indexed (dense) memory
  typedef struct packed {
    logic [ENT_W-1:0]        owner;
    logic signed [VAL_W-1:0] x;
    logic signed [VAL_W-1:0] y;
  } dense_word_t;

endpackage

FILE: src/gss_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the sparse-set store.
// Depends on gss_pkg.
interface gss_in_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      mode;
  logic [gss_pkg::ENT_W-1:0]       entity_index;
  logic [gss_pkg::GEN_W-1:0]       key_generation;
  logic signed [gss_pkg::VAL_W-1:0] vec_x;
  logic signed [gss_pkg::VAL_W-1:0] vec_y;
  logic [gss_pkg::SLOT_W-1:0]      dense_slot;

  modport source (output valid, mode, entity_index, key_generation, vec_x, vec_y,
                  dense_slot, input ready);
  modport sink   (input valid, mode, entity_index, key_generation, vec_x, vec_y,
                  dense_slot, output ready);
endinterface

interface gss_out_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [gss_pkg::SLOT_W-1:0]      found_slot;
  logic [gss_pkg::ENT_W-1:0]       found_entity;
  logic signed [gss_pkg::VAL_W-1:0] out_x;
  logic signed [gss_pkg::VAL_W-1:0] out_y;
  logic [gss_pkg::CNT_W-1:0]       entry_count;

  modport source (output valid, status, found_slot, found_entity, out_x, out_y,
                  entry_count, input ready);
  modport sink   (input valid, status, found_slot, found_entity, out_x, out_y,
                  entry_count, output ready);
endinterface

FILE: src/generational_sparse_set_store.sv
`timescale 1ns / 1ps
// Generational sparse-set store, swap-and-pop, top level.
// Depends on gss_pkg and the channel interfaces in gss_ifs.sv.
//
//   channel  | dir | transaction
//   in_ch    | in  | mode, entity_index, key_generation, vec_x, vec_y, dense_slot
//   out_ch   | out | status, found_slot, found_entity, out_x, out_y, entry_count
//
// Add, miss, and slot query: result from S_EREAD. Lookup: S_EREAD, then S_DREAD.
// Remove: the same when the key holds the last slot, else also S_LREAD and
// S_WGEN (dense read of key slot, then of last slot, then two entity writes).
// One transaction in flight; the next is taken while a result waits on out_ch.
// After reset, a pass clears every generation valid bit; in_ch.ready is low.
// A stalled result holds the sequencer in its final step.
module generational_sparse_set_store (
  input  logic      clk,
  input  logic      rst_n,
  gss_in_if.sink    in_ch,
  gss_out_if.source out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EREAD = 3'd1;
  localparam logic [2:0] S_DREAD = 3'd2;
  localparam logic [2:0] S_LREAD = 3'd3;
  localparam logic [2:0] S_WGEN  = 3'd4;

  localparam int EA_W = $clog2(gss_pkg::ENT_COUNT);

  // memories
  gss_pkg::ent_word_t   ent_mem   [gss_pkg::ENT_COUNT];
  gss_pkg::dense_word_t dense_mem [gss_pkg::MAX_ITEMS];

  gss_pkg::ent_word_t   e_rd_r;
  gss_pkg::dense_word_t d_rd_r;

  logic                       e_re, e_we_gen, e_we_slot;
  logic [EA_W-1:0]            e_raddr, e_waddr;
  logic                       e_wvalid;
  logic [gss_pkg::GEN_W-1:0]  e_wgen;
  logic [gss_pkg::SLOT_W-1:0] e_wslot;
  logic                       d_re, d_we;
  logic [gss_pkg::SLOT_W-1:0] d_raddr, d_waddr;
  gss_pkg::dense_word_t       d_wdata;

  // control and transaction registers
  logic [2:0]                      state_r, state_nxt;
  logic                            clr_r;
  logic [EA_W-1:0]                 clr_idx_r;
  logic [gss_pkg::CNT_W-1:0]       count_r, count_nxt;
  logic [1:0]                      mode_r;
  logic [gss_pkg::ENT_W-1:0]       ent_r;
  logic [gss_pkg::GEN_W-1:0]       gen_r;
  logic signed [gss_pkg::VAL_W-1:0] x_r, y_r;
  logic [gss_pkg::SLOT_W-1:0]      q_r;
  logic [gss_pkg::SLOT_W-1:0]      slot_r, slot_nxt;
  logic signed [gss_pkg::VAL_W-1:0] rx_r, ry_r, rx_nxt, ry_nxt;

  logic                            out_valid_r;
  logic [1:0]                      status_r, fin_status;
  logic [gss_pkg::SLOT_W-1:0]      fslot_r, fin_slot;
  logic [gss_pkg::ENT_W-1:0]       fent_r, fin_ent;
  logic signed [gss_pkg::VAL_W-1:0] ox_r, oy_r, fin_x, fin_y;
  logic [gss_pkg::CNT_W-1:0]       ocount_r;

  logic accept, out_free, finish, gen_match, hit;
  logic [gss_pkg::CNT_W-1:0] last;

  assign in_ch.ready = (state_r == S_IDLE) && !clr_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign gen_match = e_rd_r.valid && (e_rd_r.gen == gen_r);
  assign hit       = gen_match && ({1'b0, e_rd_r.slot} < count_r);
  assign last      = count_r - gss_pkg::CNT_W'(1);

  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    slot_nxt   = slot_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    finish     = 1'b0;
    fin_status = gss_pkg::ST_OK;
    fin_slot   = '0;
    fin_ent    = '0;
    fin_x      = '0;
    fin_y      = '0;
    e_re       = 1'b0;
    e_raddr    = in_ch.entity_index;
    e_we_gen   = 1'b0;
    e_we_slot  = 1'b0;
    e_waddr    = ent_r;
    e_wvalid   = 1'b0;
    e_wgen     = '0;
    e_wslot    = '0;
    d_re       = 1'b0;
    d_raddr    = in_ch.dense_slot;
    d_we       = 1'b0;
    d_waddr    = slot_r;
    d_wdata    = d_rd_r;

    unique case (state_r)
      S_IDLE: begin
        if (clr_r) begin
          e_we_gen = 1'b1;
          e_waddr  = clr_idx_r;
        end
        if (accept) begin
          e_re      = 1'b1;
          d_re      = 1'b1;
          state_nxt = S_EREAD;
        end
      end
      S_EREAD: begin
        case (mode_r)
          gss_pkg::MODE_ADD: begin
            if (out_free) begin
              finish = 1'b1;
              if (gen_match) begin
                fin_status = gss_pkg::ST_PRESENT;
              end else if (count_r >= gss_pkg::CNT_W'(gss_pkg::MAX_ITEMS)) begin
                fin_status = gss_pkg::ST_FULL;
              end else begin
                d_we      = 1'b1;
                d_waddr   = count_r[gss_pkg::SLOT_W-1:0];
                d_wdata   = '{owner: ent_r, x: x_r, y: y_r};
                e_we_gen  = 1'b1;
                e_we_slot = 1'b1;
                e_wvalid  = 1'b1;
                e_wgen    = gen_r;
                e_wslot   = count_r[gss_pkg::SLOT_W-1:0];
                count_nxt = count_r + gss_pkg::CNT_W'(1);
                fin_slot  = count_r[gss_pkg::SLOT_W-1:0];
                fin_ent   = ent_r;
                fin_x     = x_r;
                fin_y     = y_r;
              end
            end
          end
          gss_pkg::MODE_SLOT: begin
            if (out_free) begin
              finish = 1'b1;
              if ({1'b0, q_r} < count_r) begin
                fin_slot = q_r;
                fin_ent  = d_rd_r.owner;
                fin_x    = d_rd_r.x;
                fin_y    = d_rd_r.y;
              end else begin
                fin_status = gss_pkg::ST_MISS;
              end
            end
          end
          default: begin
            if (hit) begin
              d_re      = 1'b1;
              d_raddr   = e_rd_r.slot;
              slot_nxt  = e_rd_r.slot;
              state_nxt = S_DREAD;
            end else if (out_free) begin
              finish     = 1'b1;
              fin_status = gss_pkg::ST_MISS;
            end
          end
        endcase
      end
      S_DREAD: begin
        rx_nxt = d_rd_r.x;
        ry_nxt = d_rd_r.y;
        if (mode_r == gss_pkg::MODE_REMOVE && {1'b0, slot_r} < last) begin
          d_re      = 1'b1;
          d_raddr   = last[gss_pkg::SLOT_W-1:0];
          state_nxt = S_LREAD;
        end else if (out_free) begin
          finish   = 1'b1;
          fin_slot = slot_r;
          fin_ent  = ent_r;
          fin_x    = d_rd_r.x;
          fin_y    = d_rd_r.y;
          if (mode_r == gss_pkg::MODE_REMOVE) begin
            e_we_gen  = 1'b1;
            count_nxt = last;
          end
        end
      end
      S_LREAD: begin
        // move last entry into the freed slot, repoint its owner
        d_we      = 1'b1;
        d_waddr   = slot_r;
        d_wdata   = d_rd_r;
        e_we_slot = 1'b1;
        e_waddr   = d_rd_r.owner;
        e_wslot   = slot_r;
        state_nxt = S_WGEN;
      end
      S_WGEN: begin
        if (out_free) begin
          e_we_gen  = 1'b1;
          count_nxt = last;
          finish    = 1'b1;
          fin_slot  = slot_r;
          fin_ent   = ent_r;
          fin_x     = rx_r;
          fin_y     = ry_r;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    if (finish) begin
      state_nxt = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (e_we_gen) begin
      ent_mem[e_waddr].valid <= e_wvalid;
      ent_mem[e_waddr].gen   <= e_wgen;
    end
    if (e_we_slot) begin
      ent_mem[e_waddr].slot <= e_wslot;
    end
    if (e_re) begin
      e_rd_r <= ent_mem[e_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (d_we) begin
      dense_mem[d_waddr] <= d_wdata;
    end
    if (d_re) begin
      d_rd_r <= dense_mem[d_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + EA_W'(1);
        if (clr_idx_r == EA_W'(gss_pkg::ENT_COUNT - 1)) begin
          clr_r <= 1'b0;
        end
      end
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_ch.mode;
      ent_r  <= in_ch.entity_index;
      gen_r  <= in_ch.key_generation;
      x_r    <= in_ch.vec_x;
      y_r    <= in_ch.vec_y;
      q_r    <= in_ch.dense_slot;
    end
    slot_r <= slot_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    if (finish) begin
      status_r <= fin_status;
      fslot_r  <= fin_slot;
      fent_r   <= fin_ent;
      ox_r     <= fin_x;
      oy_r     <= fin_y;
      ocount_r <= count_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = status_r;
  assign out_ch.found_slot   = fslot_r;
  assign out_ch.found_entity = fent_r;
  assign out_ch.out_x        = ox_r;
  assign out_ch.out_y        = oy_r;
  assign out_ch.entry_count  = ocount_r;

endmodule

FILE: src/gss_checker.sv
`timescale 1ns / 1ps
// Port-level checks for the sparse-set store, bound to the top level.
// Depends on gss_pkg and generational_sparse_set_store.
module gss_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [1:0]                       status,
  input logic [gss_pkg::SLOT_W-1:0]       found_slot,
  input logic [gss_pkg::ENT_W-1:0]        found_entity,
  input logic signed [gss_pkg::VAL_W-1:0] out_x,
  input logic signed [gss_pkg::VAL_W-1:0] out_y,
  input logic [gss_pkg::CNT_W-1:0]        entry_count
);

  // valid bits are being cleared right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(entry_count))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != gss_pkg::ST_OK |->
      found_slot == '0 && found_entity == '0 && out_x == '0 && out_y == '0)
    else $error("failed transaction carries data");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == gss_pkg::ST_FULL |->
      entry_count == gss_pkg::CNT_W'(gss_pkg::MAX_ITEMS))
    else $error("full reported below capacity");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status == gss_pkg::ST_OK |->
      entry_count <= gss_pkg::CNT_W'(gss_pkg::MAX_ITEMS) &&
      ({1'b0, found_slot} < entry_count || {1'b0, found_slot} == entry_count))
    else $error("slot outside entry count");

endmodule

bind generational_sparse_set_store gss_checker u_gss_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .found_slot   (out_ch.found_slot),
  .found_entity (out_ch.found_entity),
  .out_x        (out_ch.out_x),
  .out_y        (out_ch.out_y),
  .entry_count  (out_ch.entry_count)
);

FILE: verif/generational_sparse_set_store_tb.sv
`timescale 1ns / 1ps
// Testbench for generational_sparse_set_store: directed, back-pressure, fill and random tests.
// Every reply is checked against a shadow copy of the store kept here.
// Depends on gss_pkg, the channel interfaces in gss_ifs.sv and the store RTL.
module generational_sparse_set_store_tb;

  typedef struct packed {
    logic [1:0]                       mode;
    logic [gss_pkg::ENT_W-1:0]        ent;
    logic [gss_pkg::GEN_W-1:0]        gen;
    logic signed [gss_pkg::VAL_W-1:0] x;
    logic signed [gss_pkg::VAL_W-1:0] y;
    logic [gss_pkg::SLOT_W-1:0]       qslot;
  } store_op_t;

  typedef struct packed {
    logic [1:0]                       status;
    logic [gss_pkg::SLOT_W-1:0]       slot;
    logic [gss_pkg::ENT_W-1:0]        ent;
    logic signed [gss_pkg::VAL_W-1:0] x;
    logic signed [gss_pkg::VAL_W-1:0] y;
    logic [gss_pkg::CNT_W-1:0]        count;
  } store_reply_t;

  logic clk;
  logic rst_n;

  gss_in_if  in_ch ();
  gss_out_if out_ch ();

  generational_sparse_set_store dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // shadow store
  logic [gss_pkg::VAL_W-1:0]  sh_x     [gss_pkg::MAX_ITEMS];
  logic [gss_pkg::VAL_W-1:0]  sh_y     [gss_pkg::MAX_ITEMS];
  logic [gss_pkg::ENT_W-1:0]  sh_owner [gss_pkg::MAX_ITEMS];
  logic [gss_pkg::SLOT_W-1:0] sh_slot  [gss_pkg::ENT_COUNT];
  logic [gss_pkg::GEN_W-1:0]  sh_gen   [gss_pkg::ENT_COUNT];
  bit                         sh_valid [gss_pkg::ENT_COUNT];
  logic [gss_pkg::CNT_W-1:0]  sh_count;

  store_reply_t pending_replies[$];
  int  mismatches;
  bit  src_idle;
  bit  sink_idle;
  int  hold_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic bit key_hit(logic [gss_pkg::ENT_W-1:0] e, logic [gss_pkg::GEN_W-1:0] g);
    return sh_valid[e] && sh_gen[e] == g && sh_slot[e] < sh_count;
  endfunction

  function automatic store_reply_t apply_op(store_op_t op);
    store_reply_t               r;
    logic [gss_pkg::SLOT_W-1:0] s;
    logic [gss_pkg::CNT_W-1:0]  last;
    logic [gss_pkg::SLOT_W-1:0] ls;
    logic [gss_pkg::ENT_W-1:0]  mv;
    r = '0;
    r.status = gss_pkg::ST_MISS;
    case (op.mode)
      gss_pkg::MODE_ADD: begin
        if (sh_valid[op.ent] && sh_gen[op.ent] == op.gen) begin
          r.status = gss_pkg::ST_PRESENT;
        end else if (sh_count >= gss_pkg::MAX_ITEMS) begin
          r.status = gss_pkg::ST_FULL;
        end else begin
          s = sh_count[gss_pkg::SLOT_W-1:0];
          sh_x[s] = op.x;
          sh_y[s] = op.y;
          sh_slot[op.ent] = s;
          sh_gen[op.ent] = op.gen;
          sh_valid[op.ent] = 1'b1;
          sh_owner[s] = op.ent;
          sh_count = sh_count + 1'b1;
          r = '{gss_pkg::ST_OK, s, op.ent, op.x, op.y, '0};
        end
      end
      gss_pkg::MODE_REMOVE: begin
        if (key_hit(op.ent, op.gen)) begin
          s = sh_slot[op.ent];
          r = '{gss_pkg::ST_OK, s, op.ent, sh_x[s], sh_y[s], '0};
          last = sh_count - 1'b1;
          ls = last[gss_pkg::SLOT_W-1:0];
          if (s < last) begin
            mv = sh_owner[ls];
            sh_x[s] = sh_x[ls];
            sh_y[s] = sh_y[ls];
            sh_slot[mv] = s;
            sh_owner[s] = mv;
          end
          sh_valid[op.ent] = 1'b0;
          sh_gen[op.ent] = '0;
          sh_count = last;
        end
      end
      gss_pkg::MODE_LOOKUP: begin
        if (key_hit(op.ent, op.gen)) begin
          s = sh_slot[op.ent];
          r = '{gss_pkg::ST_OK, s, op.ent, sh_x[s], sh_y[s], '0};
        end
      end
      gss_pkg::MODE_SLOT: begin
        if (op.qslot < sh_count)
          r = '{gss_pkg::ST_OK, op.qslot, sh_owner[op.qslot],
                sh_x[op.qslot], sh_y[op.qslot], '0};
      end
    endcase
    r.count = sh_count;
    return r;
  endfunction

  function automatic store_op_t make_op(logic [1:0] m, logic [gss_pkg::ENT_W-1:0] e,
                                        logic [gss_pkg::GEN_W-1:0] g,
                                        logic [gss_pkg::VAL_W-1:0] x,
                                        logic [gss_pkg::VAL_W-1:0] y,
                                        logic [gss_pkg::SLOT_W-1:0] q);
    store_op_t op;
    op = '{m, e, g, x, y, q};
    return op;
  endfunction

  function automatic logic [gss_pkg::VAL_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // one transaction on in_ch; the reply is predicted at acceptance
  task automatic send_op(input store_op_t op);
    @(negedge clk);
    if (src_idle && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= op.mode;
    in_ch.entity_index   <= op.ent;
    in_ch.key_generation <= op.gen;
    in_ch.vec_x          <= op.x;
    in_ch.vec_y          <= op.y;
    in_ch.dense_slot     <= op.qslot;
    do @(posedge clk); while (!in_ch.ready);
    pending_replies.push_back(apply_op(op));
  endtask

  task automatic report_mismatch(input string what, input store_reply_t want,
                                 input store_reply_t got);
    mismatches++;
    if (mismatches <= 10)
      $display({"%s: exp st=%0d slot=%0d ent=%0d x=%0d y=%0d cnt=%0d",
                " | got st=%0d slot=%0d ent=%0d x=%0d y=%0d cnt=%0d"},
               what, want.status, want.slot, want.ent, want.x, want.y, want.count,
               got.status, got.slot, got.ent, got.x, got.y, got.count);
  endtask

  // result checker
  always @(posedge clk) begin
    store_reply_t got;
    store_reply_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.status, out_ch.found_slot, out_ch.found_entity,
              out_ch.out_x, out_ch.out_y, out_ch.entry_count};
      if (pending_replies.size() == 0) begin
        report_mismatch("unexpected transaction", '0, got);
      end else begin
        want = pending_replies.pop_front();
        if (got.status !== want.status || got.slot !== want.slot ||
            got.ent !== want.ent || got.x !== want.x || got.y !== want.y ||
            got.count !== want.count)
          report_mismatch("mismatch", want, got);
      end
    end
  end

  // receiver: random stall bursts, plus long hold-off on request
  initial begin : sink_ready_gen
    int stall_left;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_cycles--;
      end else if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else if (sink_idle && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_op(make_op(gss_pkg::MODE_LOOKUP, 10'd5, 16'd7, 32'd1, 32'd2, 10'd0));
    send_op(make_op(gss_pkg::MODE_SLOT, 10'd0, 16'd0, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_REMOVE, 10'd0, 16'd0, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_ADD, 10'd0, 16'd0, 32'h8000_0000, 32'h7fff_ffff, 10'd0));
    send_op(make_op(gss_pkg::MODE_ADD, 10'd1023, 16'hffff, 32'hffff_ffff, 32'd0, 10'd1023));
    send_op(make_op(gss_pkg::MODE_ADD, 10'd0, 16'd0, 32'd9, 32'd9, 10'd0));
    send_op(make_op(gss_pkg::MODE_ADD, 10'd512, 16'd1234, 32'h7fff_ffff, 32'h8000_0000,
                    10'd0));
    send_op(make_op(gss_pkg::MODE_LOOKUP, 10'd0, 16'd0, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_LOOKUP, 10'd0, 16'd1, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_SLOT, 10'd0, 16'd0, 32'd0, 32'd0, 10'd2));
    send_op(make_op(gss_pkg::MODE_SLOT, 10'd0, 16'd0, 32'd0, 32'd0, 10'd3));
    send_op(make_op(gss_pkg::MODE_SLOT, 10'd0, 16'd0, 32'd0, 32'd0, 10'd1023));
    // swap-and-pop: last entry moves into slot 0
    send_op(make_op(gss_pkg::MODE_REMOVE, 10'd0, 16'd0, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_LOOKUP, 10'd512, 16'd1234, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_SLOT, 10'd0, 16'd0, 32'd0, 32'd0, 10'd0));
    // remove of the last slot, no move
    send_op(make_op(gss_pkg::MODE_REMOVE, 10'd1023, 16'hffff, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_ADD, 10'd1023, 16'h5555, 32'd11, 32'd22, 10'd0));
    // new generation over a live key orphans the old entry
    send_op(make_op(gss_pkg::MODE_ADD, 10'd1023, 16'haaaa, 32'd33, -32'sd44, 10'd0));
    send_op(make_op(gss_pkg::MODE_LOOKUP, 10'd1023, 16'h5555, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_LOOKUP, 10'd1023, 16'haaaa, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_SLOT, 10'd0, 16'd0, 32'd0, 32'd0, 10'd1));
    send_op(make_op(gss_pkg::MODE_REMOVE, 10'd1023, 16'haaaa, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_REMOVE, 10'd512, 16'd1234, 32'd0, 32'd0, 10'd0));
    send_op(make_op(gss_pkg::MODE_SLOT, 10'd0, 16'd0, 32'd0, 32'd0, 10'd0));
  endtask

  task automatic test_backpressure();
    int i;
    @(posedge clk);
    hold_cycles = 150;
    for (i = 0; i < 12; i++) begin
      if (i % 3 == 2)
        send_op(make_op(gss_pkg::MODE_SLOT, gss_pkg::ENT_W'($urandom),
                        gss_pkg::GEN_W'($urandom), $urandom, $urandom,
                        gss_pkg::SLOT_W'($urandom_range(0, 3))));
      else
        send_op(make_op(gss_pkg::MODE_ADD, gss_pkg::ENT_W'(100 + i),
                        gss_pkg::GEN_W'($urandom), rand_word(), rand_word(),
                        gss_pkg::SLOT_W'($urandom)));
    end
  endtask

  task automatic test_fill_to_full();
    logic [gss_pkg::ENT_W-1:0] e;
    logic [gss_pkg::GEN_W-1:0] g;
    e = gss_pkg::ENT_W'($urandom_range(0, 1023));
    while (sh_count < gss_pkg::MAX_ITEMS) begin
      g = sh_valid[e] ? sh_gen[e] + 1'b1 : gss_pkg::GEN_W'($urandom);
      send_op(make_op(gss_pkg::MODE_ADD, e, g, rand_word(), rand_word(),
                      gss_pkg::SLOT_W'($urandom)));
      e = e + 1'b1;
    end
    send_op(make_op(gss_pkg::MODE_SLOT, gss_pkg::ENT_W'($urandom), gss_pkg::GEN_W'($urandom),
                    $urandom, $urandom, 10'd0));
    send_op(make_op(gss_pkg::MODE_SLOT, gss_pkg::ENT_W'($urandom), gss_pkg::GEN_W'($urandom),
                    $urandom, $urandom, 10'd1023));
    send_op(make_op(gss_pkg::MODE_ADD, e, sh_gen[e] + 1'b1, rand_word(), rand_word(),
                    gss_pkg::SLOT_W'($urandom)));
    send_op(make_op(gss_pkg::MODE_ADD, e, sh_gen[e] ^ 16'h8001, rand_word(), rand_word(),
                    gss_pkg::SLOT_W'($urandom)));
    send_op(make_op(gss_pkg::MODE_ADD, e, sh_gen[e], rand_word(), rand_word(),
                    gss_pkg::SLOT_W'($urandom)));
    send_op(make_op(gss_pkg::MODE_LOOKUP, e, sh_gen[e], $urandom, $urandom,
                    gss_pkg::SLOT_W'($urandom)));
  endtask

  task automatic test_random_mix(input int n);
    int i;
    int pick;
    int add_pct;
    logic [gss_pkg::ENT_W-1:0]  e;
    logic [gss_pkg::GEN_W-1:0]  g;
    logic [gss_pkg::SLOT_W-1:0] q;
    logic [1:0]                 m;
    store_op_t op;
    for (i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      add_pct = (sh_count < 64) ? 45 : 25;
      e = ($urandom_range(0, 1) == 0) ? gss_pkg::ENT_W'($urandom_range(0, 31)) :
                                        gss_pkg::ENT_W'($urandom);
      g = gss_pkg::GEN_W'($urandom);
      q = gss_pkg::SLOT_W'($urandom);
      if (pick < add_pct) begin
        if (sh_valid[e] && $urandom_range(0, 5) == 0)
          g = sh_gen[e];
        op = make_op(gss_pkg::MODE_ADD, e, g, rand_word(), rand_word(), q);
      end else if (pick < 90) begin
        // live key picked through its dense slot, mostly
        if (sh_count > 0 && $urandom_range(0, 9) < 8) begin
          e = sh_owner[gss_pkg::SLOT_W'($urandom_range(0, sh_count - 1))];
          if (sh_valid[e])
            g = sh_gen[e];
        end
        m = (pick < add_pct + (90 - add_pct) / 2) ? gss_pkg::MODE_REMOVE :
                                                    gss_pkg::MODE_LOOKUP;
        op = make_op(m, e, g, $urandom, $urandom, q);
      end else begin
        case ($urandom_range(0, 9))
          0: q = sh_count[gss_pkg::SLOT_W-1:0];
          1, 2: q = gss_pkg::SLOT_W'($urandom);
          default: if (sh_count > 0) q = gss_pkg::SLOT_W'($urandom_range(0, sh_count - 1));
        endcase
        op = make_op(gss_pkg::MODE_SLOT, e, g, $urandom, $urandom, q);
      end
      send_op(op);
    end
  endtask

  initial begin : main_seq
    int i;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.mode = gss_pkg::MODE_ADD;
    in_ch.entity_index = '0;
    in_ch.key_generation = '0;
    in_ch.vec_x = '0;
    in_ch.vec_y = '0;
    in_ch.dense_slot = '0;
    mismatches = 0;
    hold_cycles = 0;
    src_idle = 1'b1;
    sink_idle = 1'b1;
    for (i = 0; i < gss_pkg::MAX_ITEMS; i++) begin
      sh_x[i] = '0;
      sh_y[i] = '0;
      sh_owner[i] = '0;
    end
    for (i = 0; i < gss_pkg::ENT_COUNT; i++) begin
      sh_slot[i] = '0;
      sh_gen[i] = '0;
      sh_valid[i] = 1'b0;
    end
    sh_count = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_backpressure();
    test_fill_to_full();
    test_random_mix(100);
    src_idle = 1'b0;
    sink_idle = 1'b0;
    test_random_mix(60);

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_replies.size() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
